[rtl/core/pdd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pdd_pkg;

    localparam int COLONY_W = 31;
    localparam int WLO_W    = 64;
    localparam int WHI_W    = 16;

    typedef struct packed {
        logic [COLONY_W-1:0] colony;
        logic [WLO_W-1:0]    word_low;
        logic [WHI_W-1:0]    word_high;
    } in_item_t;

    typedef struct packed {
        logic [COLONY_W-1:0] colony_echo;
        logic                repeated;
        logic                table_full;
    } out_item_t;

    typedef struct packed {
        logic                valid;
        logic [COLONY_W-1:0] colony;
        logic [WLO_W-1:0]    word_low;
        logic [WHI_W-1:0]    word_high;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_CMP
    } pdd_state_t;

endpackage

`default_nettype wire

[rtl/core/pdd_bucket_mod.sv]
`timescale 1ns / 1ps
`default_nettype none

module pdd_bucket_mod
    import pdd_pkg::*;
#(
    parameter int BUCKETS = 1024
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [COLONY_W-1:0]         colony,
    output logic                             busy,
    output logic [$clog2(BUCKETS)-1:0]       bucket
);

    localparam int BW   = $clog2(BUCKETS);
    localparam bit POW2 = ((1 << BW) == BUCKETS);

    generate
        if (POW2) begin : g_pow2
            logic [BW-1:0] bucket_reg;

            always_ff @(posedge aclk) begin
                if (start) begin
                    bucket_reg <= colony[BW-1:0];
                end
            end

            assign busy   = 1'b0;
            assign bucket = bucket_reg;
        end else begin : g_recip
            // quotient by a rounded-up reciprocal, exact for every colony value
            localparam int                  SHIFT   = COLONY_W + BW;
            localparam int                  PW      = 2 * COLONY_W + 1;
            localparam logic [63:0]         NUM     = 64'd1 << SHIFT;
            localparam logic [63:0]         DEN     = 64'(BUCKETS);
            localparam logic [63:0]         RECIP64 = (NUM + DEN - 64'd1) / DEN;
            localparam logic [COLONY_W:0]   RECIP   = RECIP64[COLONY_W:0];
            localparam logic [COLONY_W-1:0] DIV     = COLONY_W'(BUCKETS);

            logic [COLONY_W-1:0] colony_reg;
            logic [COLONY_W-1:0] quot_reg;
            logic [COLONY_W-1:0] quot_next;
            logic [PW-1:0]       prod;
            logic [COLONY_W-1:0] rem_full;
            logic [BW-1:0]       rem_reg;
            logic                busy_reg;
            logic                phase_reg;

            assign prod      = PW'(colony_reg) * PW'(RECIP);
            assign quot_next = COLONY_W'(prod >> SHIFT);
            assign rem_full  = colony_reg - quot_reg * DIV;

            // busy runs the multiply step (quotient), then the remainder step
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg  <= 1'b0;
                    phase_reg <= 1'b0;
                end else if (start) begin
                    busy_reg  <= 1'b1;
                    phase_reg <= 1'b0;
                end else if (busy_reg) begin
                    phase_reg <= 1'b1;
                    if (phase_reg) begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    colony_reg <= colony;
                end else if (busy_reg && !phase_reg) begin
                    quot_reg <= quot_next;
                end else if (busy_reg && phase_reg) begin
                    rem_reg <= rem_full[BW-1:0];
                end
            end

            assign busy   = busy_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

[rtl/core/pdd_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module pdd_table
    import pdd_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(BUCKETS)-1:0]    rd_addr,
    output entry_t [WAYS-1:0]                  rd_data,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(BUCKETS)-1:0]    wr_addr,
    input  wire entry_t [WAYS-1:0]             wr_data
);

    // one row per bucket, all ways side by side
    entry_t [WAYS-1:0] mem [BUCKETS];
    entry_t [WAYS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/pair_duplicate_detector.sv]
// an item is accepted in ST_IDLE, ST_MOD finds its bucket and reads its row, ST_CMP
//   compares and writes back; the bucket is a reciprocal remainder of the colony, or
//   its low bits when BUCKETS is a power of two; no new item is taken until the row
//   read / compare / write-back of the last one ends and its result is registered
// reset: synchronous, active low; afterwards the table sweeps BUCKETS rows clearing
//   the valid marks, one row a cycle, and takes no item until the sweep ends
`timescale 1ns / 1ps
`default_nettype none

module pair_duplicate_detector
    import pdd_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam int BW = $clog2(BUCKETS);

    // control state
    pdd_state_t      state_reg, state_next;
    logic [BW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            m_valid_reg, m_valid_next;

    // item and result registers
    in_item_t        item_reg;
    in_item_t        item_clip;
    out_item_t       m_item_reg;
    out_item_t       result;

    // bucket remainder unit
    logic            mod_start;
    logic            mod_busy;
    logic [BW-1:0]   bucket;

    // table port
    logic              tbl_rd_en;
    entry_t [WAYS-1:0] tbl_rd_data;
    logic              tbl_wr_en;
    logic [BW-1:0]     tbl_wr_addr;
    entry_t [WAYS-1:0] tbl_wr_data;
    entry_t [WAYS-1:0] row_update;

    logic            hit;
    logic            found_free;
    logic            accept_in;
    logic            out_free;

    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // the word ends at its first zero byte; every later byte reads as zero
    always_comb begin
        logic [WLO_W+WHI_W-1:0] bytes_in;
        logic [WLO_W+WHI_W-1:0] bytes_out;
        logic                   alive;
        bytes_in  = {s_item.word_high, s_item.word_low};
        bytes_out = '0;
        alive     = 1'b1;
        for (int j = 0; j < (WLO_W + WHI_W) / 8; j++) begin
            bytes_out[8*j +: 8] = alive ? bytes_in[8*j +: 8] : 8'h00;
            alive = alive && (bytes_in[8*j +: 8] != 8'h00);
        end
        item_clip.colony    = s_item.colony;
        item_clip.word_low  = bytes_out[WLO_W-1:0];
        item_clip.word_high = bytes_out[WLO_W+WHI_W-1:WLO_W];
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            item_reg <= item_clip;
        end
    end

    pdd_bucket_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .colony  (s_item.colony),
        .busy    (mod_busy),
        .bucket  (bucket)
    );

    pdd_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (tbl_rd_en),
        .rd_addr (bucket),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    // compare all ways of the bucket at once, pick the lowest free way
    always_comb begin
        hit        = 1'b0;
        found_free = 1'b0;
        row_update = tbl_rd_data;
        for (int w = 0; w < WAYS; w++) begin
            if (tbl_rd_data[w].valid) begin
                if (tbl_rd_data[w].colony == item_reg.colony &&
                    tbl_rd_data[w].word_low == item_reg.word_low &&
                    tbl_rd_data[w].word_high == item_reg.word_high) begin
                    hit = 1'b1;
                end
            end else if (!found_free) begin
                found_free              = 1'b1;
                row_update[w].valid     = 1'b1;
                row_update[w].colony    = item_reg.colony;
                row_update[w].word_low  = item_reg.word_low;
                row_update[w].word_high = item_reg.word_high;
            end
        end
        result.colony_echo = item_reg.colony;
        result.repeated    = hit;
        result.table_full  = !hit && !found_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CMP && out_free) begin
            m_item_reg <= result;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        mod_start    = 1'b0;
        tbl_rd_en    = 1'b0;
        tbl_wr_en    = 1'b0;
        tbl_wr_addr  = bucket;
        tbl_wr_data  = row_update;
        unique case (state_reg)
            ST_CLEAR: begin
                // sweep every row, dropping all valid marks
                tbl_wr_en    = 1'b1;
                tbl_wr_addr  = clr_cnt_reg;
                tbl_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BW'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                // bucket known: fetch its row
                if (!mod_busy) begin
                    tbl_rd_en  = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                // hand over the result, writing a new pair into a free way, only once
                if (out_free) begin
                    tbl_wr_en    = !hit && found_free;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // a pair never reads both as stored before and as dropped
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.repeated && m_item.table_full))
        else $error("repeated and table_full both set");

    // a new result only comes out of the compare step
    a_result_from_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_CMP))
        else $error("result raised outside compare");

    // the remainder unit only runs while its item waits for the bucket
    a_mod_in_mod_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_busy |-> state_reg == ST_MOD)
        else $error("remainder unit busy outside bucket state");

    // no item is taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("item accepted during clear");

endmodule

`default_nettype wire

[dv/pair_duplicate_detector_tb.sv]
`timescale 1ns / 1ps

module pair_duplicate_detector_tb;
    import pdd_pkg::*;

    localparam int BUCKETS     = 1024;
    localparam int WAYS        = 4;
    localparam int SLOTS       = BUCKETS * WAYS;
    localparam int HOT_BUCKETS = 16;
    localparam int WORD_POOL   = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 192;
    localparam int FLOOD_ITEMS = 60;
    localparam int REPORT_MAX  = 10;

    // clock, reset and block ports; every input starts at a known value
    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // shadow copy of the pair table, kept by the predictor
    bit                  slot_used   [SLOTS];
    logic [COLONY_W-1:0] slot_colony [SLOTS];
    logic [WLO_W-1:0]    slot_wlo    [SLOTS];
    logic [WHI_W-1:0]    slot_whi    [SLOTS];

    // verdicts waiting for the block to produce them, oldest first
    out_item_t expected_verdicts[$];

    // traffic shaping, set by the test sequence; the result side keeps the hold counts
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // stimulus pools: a few hot buckets and a few words so that repeats and
    // full buckets show up often
    int          hot_bucket [HOT_BUCKETS];
    int          word_len   [WORD_POOL];
    logic [79:0] word_chars [WORD_POOL];

    // bookkeeping
    int fail_count     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int repeats_seen   = 0;
    int drops_seen     = 0;
    int s_stall_cycles = 0;

    pair_duplicate_detector #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // only the first few failures are printed, the rest are counted
    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // a word ends at its first zero byte; anything after it does not count
    function automatic in_item_t clip_word(in_item_t raw);
        in_item_t key;
        int       i;
        bit       ended;
        key   = raw;
        ended = 1'b0;
        for (i = 0; i < 8; i++) begin
            if (ended)
                key.word_low[8*i +: 8] = 8'h00;
            else if (key.word_low[8*i +: 8] == 8'h00)
                ended = 1'b1;
        end
        if (ended || key.word_high[7:0] == 8'h00)
            key.word_high = '0;
        return key;
    endfunction

    // looks the pair up in the shadow table and inserts it when new
    function automatic out_item_t predict_verdict(in_item_t raw);
        in_item_t  key;
        out_item_t verdict;
        int        base;
        int        free_way;
        int        idx;
        int        w;
        bit        hit;
        key      = clip_word(raw);
        base     = int'(key.colony % BUCKETS) * WAYS;
        free_way = -1;
        hit      = 1'b0;
        for (w = 0; w < WAYS; w++) begin
            idx = base + w;
            if (slot_used[idx]) begin
                if (slot_colony[idx] == key.colony && slot_wlo[idx] == key.word_low &&
                    slot_whi[idx] == key.word_high)
                    hit = 1'b1;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        verdict.colony_echo = key.colony;
        verdict.repeated    = hit;
        verdict.table_full  = 1'b0;
        if (!hit) begin
            if (free_way >= 0) begin
                idx              = base + free_way;
                slot_used[idx]   = 1'b1;
                slot_colony[idx] = key.colony;
                slot_wlo[idx]    = key.word_low;
                slot_whi[idx]    = key.word_high;
            end else begin
                verdict.table_full = 1'b1;
            end
        end
        if (hit)
            repeats_seen++;
        if (verdict.table_full)
            drops_seen++;
        return verdict;
    endfunction

    function automatic in_item_t make_pair_item(logic [COLONY_W-1:0] colony,
                                                logic [WLO_W-1:0] wlo,
                                                logic [WHI_W-1:0] whi);
        in_item_t it;
        it.colony    = colony;
        it.word_low  = wlo;
        it.word_high = whi;
        return it;
    endfunction

    // builds a ten-byte word of the given length, optionally with junk past its end
    function automatic logic [79:0] make_word(int len, logic [79:0] chars, bit junk);
        logic [79:0] w;
        logic [7:0]  c;
        int          i;
        for (i = 0; i < 10; i++) begin
            c = chars[8*i +: 8];
            if (i < len)
                w[8*i +: 8] = (c == 8'h00) ? 8'h5a : c;
            else if (i == len || !junk)
                w[8*i +: 8] = 8'h00;
            else
                w[8*i +: 8] = c;
        end
        return w;
    endfunction

    function automatic in_item_t random_pair();
        in_item_t    it;
        logic [79:0] w;
        int          pick;
        int          k;
        int          colony;
        pick = $urandom_range(99);
        if (pick < 75) begin
            // well-formed traffic: hot buckets and pooled words, tight or wide mix
            if ($urandom_range(1)) begin
                colony = hot_bucket[$urandom_range(HOT_BUCKETS-1)] +
                         BUCKETS * $urandom_range(1);
                k      = $urandom_range(2);
            end else begin
                colony = hot_bucket[$urandom_range(HOT_BUCKETS-1)] +
                         BUCKETS * $urandom_range(5);
                k      = $urandom_range(WORD_POOL-1);
            end
            w = make_word(word_len[k], word_chars[k], 1'($urandom_range(1)));
        end else if (pick < 90) begin
            colony = $urandom;
            w      = make_word($urandom_range(10), 80'({$urandom, $urandom, $urandom}),
                               1'($urandom_range(1)));
        end else begin
            // raw noise, every bit free
            colony = $urandom;
            w      = 80'({$urandom, $urandom, $urandom});
        end
        it.colony    = colony[COLONY_W-1:0];
        it.word_low  = w[63:0];
        it.word_high = w[79:64];
        return it;
    endfunction

    // offers one item, with a random idle gap first; valid stays up between
    // back-to-back items and is only dropped for a gap
    task automatic offer_pair(input in_item_t pair);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= pair;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_verdicts.push_back(predict_verdict(pair));
        items_sent++;
    endtask

    // result side: random stalls, plus a long hold-off when the sequence asks
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // every accepted result is matched against the oldest pending verdict
    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready)
            s_stall_cycles++;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_verdicts.size() == 0) begin
                report_failure($sformatf(
                    "result with nothing pending: colony %0d rep %0b full %0b",
                    m_item.colony_echo, m_item.repeated, m_item.table_full));
            end else begin
                automatic out_item_t want = expected_verdicts.pop_front();
                if (m_item.colony_echo !== want.colony_echo ||
                    m_item.repeated !== want.repeated ||
                    m_item.table_full !== want.table_full)
                    report_failure($sformatf({"verdict mismatch: exp colony %0d rep %0b ",
                                              "full %0b, got colony %0d rep %0b full %0b"},
                        want.colony_echo, want.repeated, want.table_full,
                        m_item.colony_echo, m_item.repeated, m_item.table_full));
            end
        end
    end

    // corner cases: field extremes, empty word, junk past the end, full bucket
    task automatic check_directed_pairs();
        send_idle_pct = 0;
        stall_pct     = 0;
        // lowest colony, then the same pair again
        offer_pair(make_pair_item('0, 64'h61, 16'h0000));
        offer_pair(make_pair_item('0, 64'h61, 16'h0000));
        // highest colony with a full ten-byte word of all ones
        offer_pair(make_pair_item('1, '1, '1));
        offer_pair(make_pair_item('1, '1, '1));
        // empty word, then an empty word with junk after its terminator
        offer_pair(make_pair_item(31'd5, '0, '0));
        offer_pair(make_pair_item(31'd5, 64'hab12_cd34_ef56_7800, 16'h1234));
        // three-character word, then the same word with junk after it
        offer_pair(make_pair_item(31'd7, 64'h0000_0000_0063_6261, 16'h0000));
        offer_pair(make_pair_item(31'd7, 64'hff11_2233_0063_6261, 16'hbeef));
        // eight characters: the high bytes only count if character nine is set
        offer_pair(make_pair_item(31'd9, 64'h4847_4645_4443_4241, 16'haa00));
        offer_pair(make_pair_item(31'd9, 64'h4847_4645_4443_4241, 16'h5500));
        offer_pair(make_pair_item(31'd9, 64'h4847_4645_4443_4241, 16'h0000));
        // nine and ten characters differ only in character ten
        offer_pair(make_pair_item(31'd9, 64'h4847_4645_4443_4241, 16'h0049));
        offer_pair(make_pair_item(31'd9, 64'h4847_4645_4443_4241, 16'hff49));
        // same colony with another word, same word in another colony of the bucket
        offer_pair(make_pair_item('0, 64'h62, 16'h0000));
        offer_pair(make_pair_item(31'd3, 64'h61, 16'h0000));
        offer_pair(make_pair_item(COLONY_W'(3 + BUCKETS), 64'h61, 16'h0000));
        // fill one bucket, then overflow it, then revisit stored and dropped pairs
        offer_pair(make_pair_item(31'd100, 64'h78, 16'h0000));
        offer_pair(make_pair_item(COLONY_W'(100 + BUCKETS), 64'h78, 16'h0000));
        offer_pair(make_pair_item(COLONY_W'(100 + 2 * BUCKETS), 64'h78, 16'h0000));
        offer_pair(make_pair_item(COLONY_W'(100 + 3 * BUCKETS), 64'h78, 16'h0000));
        offer_pair(make_pair_item(COLONY_W'(100 + 4 * BUCKETS), 64'h78, 16'h0000));
        offer_pair(make_pair_item(31'd100, 64'h78, 16'h0000));
        offer_pair(make_pair_item(COLONY_W'(100 + 4 * BUCKETS), 64'h78, 16'h0000));
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_rate, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        repeat (count)
            offer_pair(random_pair());
    endtask

    // long receiver hold-off while the sender keeps going, so the block backs up
    task automatic check_input_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        repeat (FLOOD_ITEMS)
            offer_pair(random_pair());
    endtask

    // wait for every pending verdict, let the pipe drain, then report
    task automatic finish_run();
        int waited;
        waited        = 0;
        s_valid      <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        while (expected_verdicts.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40)
            @(posedge aclk);
        if (expected_verdicts.size() != 0)
            report_failure($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
        $display("summary: %0d pairs sent, %0d results checked, %0d repeats, %0d drops",
                 items_sent, results_seen, repeats_seen, drops_seen);
        $display("summary: input held off for %0d cycles, %0d failures",
                 s_stall_cycles, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    endtask

    initial begin
        int i;
        int j;
        for (i = 0; i < HOT_BUCKETS; i++)
            hot_bucket[i] = $urandom_range(BUCKETS - 1);
        for (i = 0; i < WORD_POOL; i++) begin
            word_len[i] = (i == 0) ? 0 : (i == 1) ? 10 : $urandom_range(10);
            for (j = 0; j < 10; j++)
                word_chars[i][8*j +: 8] = 8'($urandom_range(255, 1));
        end
        // reset, then the block sweeps its table before taking items
        repeat (5)
            @(posedge aclk);
        aresetn <= 1'b1;
        check_directed_pairs();
        run_random_phase(0, 0, PHASE_ITEMS);
        run_random_phase(68, 0, PHASE_ITEMS);
        run_random_phase(0, 68, PHASE_ITEMS);
        run_random_phase(34, 34, PHASE_ITEMS);
        check_input_backpressure();
        finish_run();
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/core/pdd_pkg.sv
rtl/core/pdd_bucket_mod.sv
rtl/core/pdd_table.sv
rtl/core/pair_duplicate_detector.sv
dv/pair_duplicate_detector_tb.sv
